// ===== hdl/ena_pkg.sv =====
// Package: shared types and constants for the extended next-after block.
package ena_pkg;

  localparam logic [14:0] ExpAll   = 15'h7FFF;
  localparam logic [63:0] IntBit   = 64'h8000000000000000;
  localparam logic [63:0] QuietBit = 64'h4000000000000000;
  localparam logic [63:0] FracAll  = 64'h7FFFFFFFFFFFFFFF;
  localparam logic [63:0] SigAll   = 64'hFFFFFFFFFFFFFFFF;

  typedef struct packed {
    logic        s;
    logic [14:0] e;
    logic [63:0] m;
  } xval_t;

  typedef struct packed {
    xval_t v;
    logic  rerr;
  } result_t;

endpackage

// ===== hdl/ena_core.sv =====
// Combinational next-after datapath for one operand pair.
module ena_core (
  input  ena_pkg::xval_t   a_i,
  input  ena_pkg::xval_t   b_i,
  output ena_pkg::result_t res_o
);

  logic        a_nan, b_nan, a_zero, b_zero;
  ena_pkg::xval_t a, b, r, nr;
  logic [14:0] ea, eb;
  logic        a_gt, b_gt, mag_eq, up;
  logic [63:0] m_inc, m_dec;
  logic [14:0] e_dec;

  always_comb begin
    a = a_i;
    b = b_i;
    r = a_i;
    a_nan = 1'b0;
    b_nan = 1'b0;
    // Invalid encodings become the default quiet NaN.
    if (a.e == ena_pkg::ExpAll) begin
      if (!a.m[63]) a = '{1'b1, ena_pkg::ExpAll, ena_pkg::IntBit | ena_pkg::QuietBit};
      a_nan = (a.m != ena_pkg::IntBit);
    end else if (a.e != '0 && !a.m[63]) begin
      a = '{1'b1, ena_pkg::ExpAll, ena_pkg::IntBit | ena_pkg::QuietBit};
      a_nan = 1'b1;
    end
    if (b.e == ena_pkg::ExpAll) begin
      if (!b.m[63]) b = '{1'b1, ena_pkg::ExpAll, ena_pkg::IntBit | ena_pkg::QuietBit};
      b_nan = (b.m != ena_pkg::IntBit);
    end else if (b.e != '0 && !b.m[63]) begin
      b = '{1'b1, ena_pkg::ExpAll, ena_pkg::IntBit | ena_pkg::QuietBit};
      b_nan = 1'b1;
    end
    a_zero = (a.e == '0) && (a.m == '0);
    b_zero = (b.e == '0) && (b.m == '0);
    ea = a_zero ? 15'd0 : ((a.e == '0) ? 15'd1 : a.e);
    eb = b_zero ? 15'd0 : ((b.e == '0) ? 15'd1 : b.e);
    a_gt   = (ea > eb) || ((ea == eb) && (a.m > b.m));
    b_gt   = (eb > ea) || ((ea == eb) && (b.m > a.m));
    mag_eq = !a_gt && !b_gt;

    // Step the start magnitude; pseudo-denormal start counts as exponent 1.
    nr = a;
    if (nr.e == '0 && nr.m[63]) nr.e = 15'd1;
    up    = !b_zero && (b.s == a.s) && b_gt;
    m_inc = nr.m + 64'd1;
    m_dec = nr.m - 64'd1;
    e_dec = nr.e - 15'd1;
    if (up) begin
      if (nr.e == '0) begin
        nr.m = m_inc;
        if (m_inc == ena_pkg::IntBit) nr.e = 15'd1;
      end else if (nr.m == ena_pkg::SigAll) begin
        nr.m = ena_pkg::IntBit;
        nr.e = nr.e + 15'd1;
      end else begin
        nr.m = m_inc;
      end
    end else if (nr.e == '0) begin
      nr.m = m_dec;
    end else if (nr.m == ena_pkg::IntBit) begin
      nr.e = e_dec;
      nr.m = (e_dec == '0) ? ena_pkg::FracAll : ena_pkg::SigAll;
    end else begin
      nr.m = m_dec;
    end

    priority if (a_nan || b_nan) begin
      r = (a_nan && b_nan) ? ((b.m > a.m) ? b : a) : (a_nan ? a : b);
      r.m = r.m | ena_pkg::IntBit | ena_pkg::QuietBit;
      res_o = '{r, 1'b0};
    end else if ((a_zero && b_zero) || (a.s == b.s && mag_eq)) begin
      res_o = '{b, 1'b0};
    end else if (a_zero) begin
      res_o = '{'{b.s, 15'd0, 64'd1}, 1'b1};
    end else begin
      res_o = '{nr, (nr.e == ena_pkg::ExpAll) || (nr.e == '0)};
    end
  end

endmodule

// ===== hdl/extended_next_after.sv =====
// Top level: registered x87 extended next-after stream block.
//
// Input stream (s_axis_*): one word per operand pair, start value and target
// value each as sign, 15-bit biased exponent and 64-bit significand.
// Output stream (m_axis_*): one word per input word, the neighbor of the start
// toward the target, plus a range flag (infinite, subnormal or zero step).
//
// An input register feeds the combinational next-after logic, whose output
// lands in a result register.
// Throughput: one word per cycle; both stages advance together whenever the
// result register is empty or being drained, so the block streams with no
// bubbles.
// Stall: when m_axis_tready is low with a result held, the result stage holds;
// an empty input stage still loads; s_axis_tready drops only once it is full.
// Reset: rst_ni clears both stage valid bits; no words are in flight.
module extended_next_after (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_sign[0], start_exp[15:1], start_sig[79:16],
  // toward_sign[80], toward_exponent[95:81], toward_significand[159:96]
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_sign[0], result_exponent[15:1], result_significand[79:16],
  // range_error[80], zero pad [87:81]
  output logic [87:0]  m_axis_tdata
);

  logic             in_vld_q, out_vld_q, adv;
  ena_pkg::xval_t   a_q, b_q;
  ena_pkg::result_t res, res_q;

  // The pipe advances unless a held result is stalled.
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv || !in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) out_vld_q <= in_vld_q;
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      a_q <= '{s_axis_tdata[0], s_axis_tdata[15:1], s_axis_tdata[79:16]};
      b_q <= '{s_axis_tdata[80], s_axis_tdata[95:81], s_axis_tdata[159:96]};
    end
    if (adv && in_vld_q) res_q <= res;
  end

  ena_core u_core (
    .a_i  (a_q),
    .b_i  (b_q),
    .res_o(res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, res_q.rerr, res_q.v.m, res_q.v.e, res_q.v.s};

endmodule

// ===== hdl/ena_checker.sv =====
// Port-level checker for the extended next-after block, with its bind.
module ena_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [87:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[87:81] == 7'd0)
    else $error("pad bits set");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("result missing after two cycles");

endmodule

bind extended_next_after ena_checker u_ena_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
